@@ design/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define LMFB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LMFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lmfb_pkg.sv @@
// package: types and constants of the led matrix frame buffer flusher
`timescale 1ns / 1ps
`default_nettype none

package lmfb_pkg;

  localparam int NumChainsDef       = 2;
  localparam int DevicesPerChainDef = 4;
  localparam int RowsPerDevice      = 8;
  localparam int RowMirror          = 7;

  typedef enum logic [2:0] {
    KIND_PIXEL       = 3'd0,
    KIND_FLUSH_ROW   = 3'd1,
    KIND_FLUSH_CHAIN = 3'd2,
    KIND_CLEAR_CHAIN = 3'd3,
    KIND_CLEAR_ALL   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_FLUSH
  } state_e;

  // side information that travels with a memory read of a flush
  typedef struct packed {
    logic       chain;
    logic [2:0] row;
    logic       frame_end;
    logic       last;
  } word_meta_t;

endpackage

`default_nettype wire

@@ design/led_matrix_frame_buffer_flusher.sv @@
// top level: frame store and word sequencer for daisy-chained led matrix chains
`timescale 1ns / 1ps
`default_nettype none

// Frame store of one byte per row for every device of every chain, held in a
// single synchronous memory (one write port, one read port, registered read
// data). A pixel write is a read-modify-write (accept, read, write back);
// its read waits while the word side stalls and an earlier flush word still
// sits in the read data register. A row flush sends DEVICES_PER_CHAIN words
// and a chain flush 8 * DEVICES_PER_CHAIN words, one word per cycle from the
// single memory read port when the output side takes every word; the next
// command is accepted as soon as the last read of a flush has been issued.
// Clear chain and clear all act on acceptance alone: each memory entry has a
// valid bit, reset and the clears drop these bits, and an entry without its
// valid bit reads as zero, so no clearing pass is needed after reset. Words
// come out farthest device first; frame_end marks the last word of a
// chip-select frame and last the final word of the command.
`include "assert_macros.svh"

module led_matrix_frame_buffer_flusher #(
  parameter int NUM_CHAINS        = lmfb_pkg::NumChainsDef,
  parameter int DEVICES_PER_CHAIN = lmfb_pkg::DevicesPerChainDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // command side
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] kind_i,
  input  wire logic       chain_index_i,
  input  wire logic [2:0] device_index_i,
  input  wire logic [2:0] column_i,
  input  wire logic [2:0] row_index_i,
  input  wire logic       pixel_on_i,
  // word side
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            chain_select_o,
  output logic [3:0]      register_address_o,
  output logic [7:0]      register_data_o,
  output logic            frame_end_o,
  output logic            last_o
);

  localparam int Rows      = lmfb_pkg::RowsPerDevice;
  localparam int Depth     = NUM_CHAINS * DEVICES_PER_CHAIN * Rows;
  localparam int AddrW     = $clog2(Depth);
  localparam int DevW      = (DEVICES_PER_CHAIN > 1) ? $clog2(DEVICES_PER_CHAIN) : 1;
  localparam int ChainSpan = DEVICES_PER_CHAIN * Rows;
  localparam logic [DevW-1:0] DevLast = DevW'(DEVICES_PER_CHAIN - 1);
  localparam logic [2:0]      RowLast = 3'(Rows - 1);

  // frame store and its read data register
  logic [7:0]       mem_q [Depth];
  logic [7:0]       rdata_q;
  logic [Depth-1:0] vld_q, vld_d;

  lmfb_pkg::state_e state_q, state_d;
  logic [2:0]       row_q, row_d;
  logic [DevW-1:0]  dev_q, dev_d;

  // command fields held for the duration of a command
  logic             chain_q;
  logic             single_q;
  logic [AddrW-1:0] pix_addr_q;
  logic [2:0]       pix_col_q;
  logic             pix_on_q;

  // memory access controls
  logic             rd_en;
  logic [AddrW-1:0] raddr;
  logic             mem_we;
  logic [7:0]       wdata;
  logic [7:0]       old_byte;
  logic [7:0]       bit_mask;

  // pending flush read: data in rdata_q, waiting for the output register
  logic                 rd_pend_q, rd_pend_d;
  logic                 rd_vld_q;
  lmfb_pkg::word_meta_t rd_meta_q;
  lmfb_pkg::word_meta_t issue_meta;
  logic                 issue_flush;

  // output word register
  logic                 out_valid_q, out_valid_d;
  lmfb_pkg::word_meta_t out_meta_q;
  logic [7:0]           out_data_q;

  logic in_fire;
  logic chain_ok;
  logic dev_ok;
  logic out_free;
  logic drain;
  lmfb_pkg::kind_e kind;

  assign kind     = lmfb_pkg::kind_e'(kind_i);
  assign chain_ok = int'(chain_index_i) < NUM_CHAINS;
  assign dev_ok   = int'(device_index_i) < DEVICES_PER_CHAIN;

  assign in_ready_o = (state_q == lmfb_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // the pending read moves on whenever the output register is free
  assign out_free = !out_valid_q || out_ready_i;
  assign drain    = rd_pend_q && out_free;

  // read-modify-write of one pixel bit
  assign old_byte = rd_vld_q ? rdata_q : 8'd0;
  assign bit_mask = 8'd1 << pix_col_q;
  assign wdata    = pix_on_q ? (old_byte | bit_mask) : (old_byte & ~bit_mask);

  // tags of the word being read by a flush
  always_comb begin
    issue_meta.chain     = chain_q;
    issue_meta.row       = row_q;
    issue_meta.frame_end = (dev_q == '0);
    issue_meta.last      = (dev_q == '0) && (single_q || row_q == RowLast);
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    dev_d       = dev_q;
    rd_en       = 1'b0;
    raddr       = pix_addr_q;
    mem_we      = 1'b0;
    issue_flush = 1'b0;
    case (state_q)
      lmfb_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (kind)
            lmfb_pkg::KIND_PIXEL: begin
              if (chain_ok && dev_ok) begin
                state_d = lmfb_pkg::ST_PIX_RD;
              end
            end
            lmfb_pkg::KIND_FLUSH_ROW: begin
              if (chain_ok) begin
                state_d = lmfb_pkg::ST_FLUSH;
                row_d   = row_index_i;
                dev_d   = DevLast;
              end
            end
            lmfb_pkg::KIND_FLUSH_CHAIN: begin
              if (chain_ok) begin
                state_d = lmfb_pkg::ST_FLUSH;
                row_d   = 3'd0;
                dev_d   = DevLast;
              end
            end
            default: begin
            end
          endcase
        end
      end
      lmfb_pkg::ST_PIX_RD: begin
        // wait until the read data register no longer holds a flush word
        if (!rd_pend_q || drain) begin
          rd_en   = 1'b1;
          state_d = lmfb_pkg::ST_PIX_WR;
        end
      end
      lmfb_pkg::ST_PIX_WR: begin
        mem_we  = 1'b1;
        state_d = lmfb_pkg::ST_IDLE;
      end
      lmfb_pkg::ST_FLUSH: begin
        raddr = AddrW'((int'(chain_q) * DEVICES_PER_CHAIN + int'(dev_q)) * Rows
                       + int'(row_q));
        if (!rd_pend_q || drain) begin
          rd_en       = 1'b1;
          issue_flush = 1'b1;
          if (dev_q == '0) begin
            if (single_q || row_q == RowLast) begin
              state_d = lmfb_pkg::ST_IDLE;
            end else begin
              row_d = row_q + 3'd1;
              dev_d = DevLast;
            end
          end else begin
            dev_d = dev_q - DevW'(1);
          end
        end
      end
      default: begin
        state_d = lmfb_pkg::ST_IDLE;
      end
    endcase
  end

  // valid bits: a pixel write sets its entry's bit, clears drop whole chains or the whole store at once
  always_comb begin
    vld_d = vld_q;
    if (mem_we) begin
      vld_d[pix_addr_q] = 1'b1;
    end
    if (in_fire && kind == lmfb_pkg::KIND_CLEAR_ALL) begin
      vld_d = '0;
    end else if (in_fire && kind == lmfb_pkg::KIND_CLEAR_CHAIN && chain_ok) begin
      for (int c = 0; c < NUM_CHAINS; c++) begin
        for (int e = 0; e < ChainSpan; e++) begin
          if (int'(chain_index_i) == c) begin
            vld_d[c * ChainSpan + e] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    rd_pend_d = rd_pend_q;
    if (issue_flush) begin
      rd_pend_d = 1'b1;
    end else if (drain) begin
      rd_pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (drain) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmfb_pkg::ST_IDLE;
      row_q       <= '0;
      dev_q       <= '0;
      vld_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      dev_q       <= dev_d;
      vld_q       <= vld_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command fields
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chain_q    <= chain_index_i;
      single_q   <= (kind == lmfb_pkg::KIND_FLUSH_ROW);
      pix_addr_q <= AddrW'((int'(chain_index_i) * DEVICES_PER_CHAIN
                            + int'(device_index_i)) * Rows
                           + (lmfb_pkg::RowMirror - int'(row_index_i)));
      pix_col_q  <= column_i;
      pix_on_q   <= pixel_on_i;
    end
  end

  // frame store memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pix_addr_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // valid bit and tags of the read in flight
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_vld_q <= vld_q[raddr];
    end
    if (issue_flush) begin
      rd_meta_q <= issue_meta;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_meta_q <= rd_meta_q;
      out_data_q <= rd_vld_q ? rdata_q : 8'd0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign chain_select_o     = out_meta_q.chain;
  assign register_address_o = {1'b0, out_meta_q.row} + 4'd1;
  assign register_data_o    = out_data_q;
  assign frame_end_o        = out_meta_q.frame_end;
  assign last_o             = out_meta_q.last;

  // a pending flush word is never overwritten while the output is stalled
  `LMFB_ASSERT(a_pend_held, clk_i, rst_ni,
    rd_pend_q && out_valid_o && !out_ready_i |=> rd_pend_q && $stable(rd_meta_q),
    "pending flush word lost under output stall")

  // the pixel read-back never shares the read register with a flush word
  `LMFB_ASSERT(a_pix_no_pend, clk_i, rst_ni,
    state_q == lmfb_pkg::ST_PIX_WR |-> !rd_pend_q,
    "pixel read-modify-write overlaps a pending flush word")

  // the last word of a command always closes a chip-select frame
  `LMFB_ASSERT(a_last_frame, clk_i, rst_ni,
    out_valid_o && last_o |-> frame_end_o,
    "last word without frame end")

  // issuing the final read of a flush returns the sequencer to idle
  `LMFB_ASSERT(a_flush_done, clk_i, rst_ni,
    issue_flush && issue_meta.last |=> state_q == lmfb_pkg::ST_IDLE,
    "flush sequencer did not finish after its final word")

endmodule

`default_nettype wire
